// ----- design/baro_temp_pressure_compensate_core_defines.svh -----
// Assertion macros used by the compensation core back end.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_CORE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define BTPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/btpc_pkg.sv -----
// Shared types and constants for the compensation core.
// No dependencies; imported by every module of the block but btpc_fifo.
package btpc_pkg;

    localparam int CAL_W = 48;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W = 64;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_INIT = 3'd1,
        ST_BUS_ERR  = 3'd2,
        ST_DATA_ERR = 3'd3,
        ST_COMP_ERR = 3'd4
    } t_status;

    // calibration register set
    typedef struct packed {
        logic             calibrated;
        logic [CAL_W-1:0] temp;
        logic [CAL_W-1:0] press_a;
        logic [CAL_W-1:0] press_b;
        logic [CAL_W-1:0] press_c;
    } t_cal;

    // classified item handed from front to back
    typedef struct packed {
        t_status     status;
        logic [19:0] adc_p;
        logic [31:0] a;
        logic [31:0] b;
    } t_job;

    // finished result
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        t_status     status;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- design/btpc_fifo.sv -----
// Small generic register queue with registered storage.
// No dependencies; used between front and back and at the result side.
module btpc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/btpc_front.sv -----
// Front end: unpacks raw bytes, classifies errors, forms temperature deltas.
// Depends on btpc_pkg.
module btpc_front (
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_bus_failed,
    input  logic [7:0]      i_press_msb,
    input  logic [7:0]      i_press_lsb,
    input  logic [7:0]      i_press_xlsb,
    input  logic [7:0]      i_temp_msb,
    input  logic [7:0]      i_temp_lsb,
    input  logic [7:0]      i_temp_xlsb,
    input  btpc_pkg::t_cal  i_cal,
    input  logic            i_q_full,
    output logic            o_q_push,
    output btpc_pkg::t_job  o_job
);
    import btpc_pkg::*;

    localparam logic [19:0] RAW_INVALID = 20'h80000;

    logic [19:0] w_adc_p;
    logic [19:0] w_adc_t;
    logic [15:0] w_t1;

    assign w_adc_p = {i_press_msb, i_press_lsb, i_press_xlsb[7:4]};
    assign w_adc_t = {i_temp_msb, i_temp_lsb, i_temp_xlsb[7:4]};
    assign w_t1    = i_cal.temp[15:0];

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    // classify in priority order and precompute the two temperature deltas
    always_comb begin
        o_job.adc_p = w_adc_p;
        o_job.a     = 32'(w_adc_t >> 3) - {15'd0, w_t1, 1'b0};
        o_job.b     = 32'(w_adc_t >> 4) - {16'd0, w_t1};
        if (!i_cal.calibrated) begin
            o_job.status = ST_NOT_INIT;
        end else if (i_bus_failed) begin
            o_job.status = ST_BUS_ERR;
        end else if (w_adc_p == RAW_INVALID || w_adc_t == RAW_INVALID) begin
            o_job.status = ST_DATA_ERR;
        end else begin
            o_job.status = ST_OK;
        end
    end

endmodule

// ----- design/btpc_div.sv -----
// Serial signed 64-bit divider, truncating toward zero, one bit per cycle.
// Depends on btpc_pkg.
module btpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_div_req  i_req,
    output btpc_pkg::t_div_rsp  o_rsp
);
    import btpc_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_d;
    logic             r_neg;
    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_diff;

    // restoring step on magnitudes
    assign w_shift = {r_rem, r_q[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? (DIV_W'(0) - r_q) : r_q;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.num[DIV_W-1] ^ i_req.den[DIV_W-1];
            r_q   <= i_req.num[DIV_W-1] ? (DIV_W'(0) - i_req.num) : i_req.num;
            r_d   <= i_req.den[DIV_W-1] ? (DIV_W'(0) - i_req.den) : i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                r_rem <= w_diff[DIV_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- design/btpc_back.sv -----
// Back end: sequencer running the compensation on one shared 32x32 multiplier
// and the serial divider. Depends on btpc_pkg and the assertion macro header.
`include "baro_temp_pressure_compensate_core_defines.svh"

module btpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_cal      i_cal,
    input  logic                i_job_empty,
    output logic                o_job_pop,
    input  btpc_pkg::t_job      i_job,
    input  logic                i_res_full,
    output logic                o_res_push,
    output btpc_pkg::t_res      o_res,
    output btpc_pkg::t_div_req  o_div,
    input  btpc_pkg::t_div_rsp  i_div
);
    import btpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // program steps
    localparam logic [4:0] STEP_TA  = 5'd0;
    localparam logic [4:0] STEP_TB  = 5'd1;
    localparam logic [4:0] STEP_TC  = 5'd2;
    localparam logic [4:0] STEP_TF  = 5'd3;
    localparam logic [4:0] STEP_P0  = 5'd4;
    localparam logic [4:0] STEP_P1  = 5'd5;
    localparam logic [4:0] STEP_P2  = 5'd6;
    localparam logic [4:0] STEP_P3  = 5'd7;
    localparam logic [4:0] STEP_P4  = 5'd8;
    localparam logic [4:0] STEP_P5  = 5'd9;
    localparam logic [4:0] STEP_PN  = 5'd10;
    localparam logic [4:0] STEP_P6  = 5'd11;
    localparam logic [4:0] STEP_P7  = 5'd12;
    localparam logic [4:0] STEP_P8  = 5'd13;
    localparam logic [4:0] STEP_P9  = 5'd14;
    localparam logic [4:0] STEP_PF  = 5'd15;
    localparam logic [4:0] STEP_PG  = 5'd16;
    localparam logic [4:0] STEP_CHK = 5'd17;

    localparam logic [63:0] P_MAX = 64'h0000_00FF_FFFF_FF00;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    t_state      r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic [1:0]  r_k;
    t_job        r_job;
    t_status     r_status;
    logic [31:0] r_tfine, r_tx, r_tout, r_press;
    logic [63:0] r_prod, r_acc;
    logic [63:0] r_v1, r_sq, r_v2, r_w, r_den, r_p, r_e;

    logic [63:0] w_x, w_y, w_mul, w_prod, w_pd, w_p1, w_p2, w_p3, w_p4;
    logic [63:0] w_p5, w_p6, w_p7, w_p8, w_p9, w_t2, w_t3;
    logic [31:0] w_mx, w_my, w_t5;
    logic        w_is_mul, w_adv;
    logic        w_div_start;

    // calibration words
    assign w_t2 = sx16(i_cal.temp[31:16]);
    assign w_t3 = sx16(i_cal.temp[47:32]);
    assign w_p1 = {48'd0, i_cal.press_a[15:0]};
    assign w_p2 = sx16(i_cal.press_a[31:16]);
    assign w_p3 = sx16(i_cal.press_a[47:32]);
    assign w_p4 = sx16(i_cal.press_b[15:0]);
    assign w_p5 = sx16(i_cal.press_b[31:16]);
    assign w_p6 = sx16(i_cal.press_b[47:32]);
    assign w_p7 = sx16(i_cal.press_c[15:0]);
    assign w_p8 = sx16(i_cal.press_c[31:16]);
    assign w_p9 = sx16(i_cal.press_c[47:32]);

    assign w_pd = sra64(r_p, 13);
    assign w_t5 = {r_tfine[29:0], 2'b00} + r_tfine + 32'd128;

    // operand select per step
    always_comb begin
        w_x      = '0;
        w_y      = '0;
        w_is_mul = 1'b1;
        case (r_step)
            STEP_TA: begin w_x = sx32(r_job.a); w_y = w_t2; end
            STEP_TB: begin w_x = sx32(r_job.b); w_y = sx32(r_job.b); end
            STEP_TC: begin w_x = sx32(r_tx);    w_y = w_t3; end
            STEP_P0: begin w_x = r_v1;          w_y = r_v1; end
            STEP_P1: begin w_x = r_sq;          w_y = w_p6; end
            STEP_P2: begin w_x = r_v1;          w_y = w_p5; end
            STEP_P3: begin w_x = r_sq;          w_y = w_p3; end
            STEP_P4: begin w_x = r_v1;          w_y = w_p2; end
            STEP_P5: begin w_x = r_w;           w_y = w_p1; end
            STEP_P6: begin w_x = r_w;           w_y = 64'd3125; end
            STEP_P7: begin w_x = w_p9;          w_y = w_pd; end
            STEP_P8: begin w_x = r_e;           w_y = w_pd; end
            STEP_P9: begin w_x = w_p8;          w_y = r_p; end
            default: w_is_mul = 1'b0;
        endcase
    end

    // 64x64 low product from three 32x32 partial products
    assign w_mx   = (r_k == 2'd2) ? w_x[63:32] : w_x[31:0];
    assign w_my   = (r_k == 2'd1) ? w_y[63:32] : w_y[31:0];
    assign w_prod = {32'd0, w_mx} * {32'd0, w_my};
    assign w_mul  = r_acc + {r_prod[31:0], 32'd0};
    assign w_adv  = (r_state == S_RUN) && (!w_is_mul || r_k == 2'd3);

    assign o_div.start = w_div_start;
    assign o_div.num   = w_mul;
    assign o_div.den   = r_den;

    assign o_res.temp   = r_tout;
    assign o_res.press  = r_press;
    assign o_res.status = r_status;

    // sequencer control
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_job_pop   = 1'b0;
        o_res_push  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_step    = STEP_TA;
                    n_state   = (i_job.status == ST_OK) ? S_RUN : S_DONE;
                end
            end
            S_RUN: begin
                if (w_adv) begin
                    n_step = r_step + 1'b1;
                    if (r_step == STEP_PN && r_den == '0) begin
                        n_state = S_DONE;
                    end else if (r_step == STEP_P6) begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else if (r_step == STEP_CHK) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (i_div.done) begin
                    n_state = S_RUN;
                end
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_TA;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_state == S_RUN && w_is_mul) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job    <= i_job;
            r_status <= i_job.status;
            r_tout   <= '0;
            r_press  <= '0;
        end
        // partial-product accumulation
        if (r_state == S_RUN && w_is_mul) begin
            case (r_k)
                2'd0: r_prod <= w_prod;
                2'd1: begin r_acc <= r_prod; r_prod <= w_prod; end
                2'd2: begin r_acc <= w_mul;  r_prod <= w_prod; end
                default: ;
            endcase
        end
        if (r_state == S_DIV && i_div.done) begin
            r_p <= i_div.quot;
        end
        // step write-back
        if (w_adv) begin
            case (r_step)
                STEP_TA: r_tfine <= sra32(w_mul[31:0], 11);
                STEP_TB: r_tx    <= sra32(w_mul[31:0], 12);
                STEP_TC: r_tfine <= r_tfine + sra32(w_mul[31:0], 14);
                STEP_TF: begin
                    r_tout <= sra32(w_t5, 8);
                    r_v1   <= sx32(r_tfine) - 64'd128000;
                end
                STEP_P0: r_sq <= w_mul;
                STEP_P1: r_v2 <= w_mul;
                STEP_P2: r_v2 <= r_v2 + (w_mul << 17) + (w_p4 << 35);
                STEP_P3: r_w  <= sra64(w_mul, 8);
                STEP_P4: r_w  <= r_w + (w_mul << 12) + 64'h0000_8000_0000_0000;
                STEP_P5: r_den <= sra64(w_mul, 33);
                STEP_PN: begin
                    if (r_den == '0) begin
                        r_status <= ST_COMP_ERR;
                    end
                    r_w <= ((64'd1048576 - {44'd0, r_job.adc_p}) << 31) - r_v2;
                end
                STEP_P7: r_e  <= w_mul;
                STEP_P8: r_e  <= sra64(w_mul, 25);
                STEP_P9: r_sq <= sra64(w_mul, 19);
                STEP_PF: r_p  <= r_p + r_e + r_sq;
                STEP_PG: r_p  <= sra64(r_p, 8) + (w_p7 << 4);
                STEP_CHK: begin
                    if (r_p[63] || r_p == '0 || r_p > P_MAX) begin
                        r_status <= ST_COMP_ERR;
                    end else begin
                        r_press <= r_p[39:8];
                    end
                end
                default: ;
            endcase
        end
    end

    `BTPC_ASSERT_NOW(a_div_start_run, i_clk, i_rst_n, o_div.start,
        r_state == S_RUN && r_step == STEP_P6, "divider started outside its step")
    `BTPC_ASSERT_NOW(a_push_done, i_clk, i_rst_n, o_res_push,
        r_state == S_DONE, "result pushed outside done state")
    `BTPC_ASSERT_NOW(a_early_zero, i_clk, i_rst_n,
        o_res_push && r_status != ST_OK && r_status != ST_COMP_ERR,
        r_tout == '0 && r_press == '0, "early error result not zero")
    `BTPC_ASSERT_NEXT(a_pop_leaves_idle, i_clk, i_rst_n, o_job_pop,
        r_state != S_IDLE, "job taken but sequencer stayed idle")

endmodule

// ----- design/baro_temp_pressure_compensate_core.sv -----
// Barometric compensation core: item queue in, result queue out. An item with
// an early error (not calibrated, bus failure, invalid raw value) is only taken
// and handed on by the back end; a computed item runs thirteen products on one
// shared 32x32 multiplier (three for the temperature, ten 64-bit ones for the
// pressure), five other steps, the taking of the item, the handing on of the
// result and the serial divider (64 quotient bits, then a done strobe). A zero
// divisor ends the item before the divider is started. Items are taken every
// cycle until the input queue fills; results wait in the output queue.
// Depends on btpc_pkg, btpc_fifo, btpc_front, btpc_div, btpc_back.
module baro_temp_pressure_compensate_core #(
    parameter int JOB_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_bus_failed,
    input  logic [7:0]                     i_press_msb,
    input  logic [7:0]                     i_press_lsb,
    input  logic [7:0]                     i_press_xlsb,
    input  logic [7:0]                     i_temp_msb,
    input  logic [7:0]                     i_temp_lsb,
    input  logic [7:0]                     i_temp_xlsb,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [31:0]             o_temp_centi_deg,
    output logic [31:0]                    o_pressure_pa,
    output logic [2:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [btpc_pkg::CAL_W-1:0]     i_cfg_data
);
    import btpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_C = 3'd4;

    t_cal     r_cal;
    t_job     w_job_in, w_job_out;
    t_res     w_res_in, w_res_out;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     w_job_push, w_job_full, w_job_pop, w_job_empty;
    logic     w_res_push, w_res_full;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CALIBRATED:  r_cal.calibrated <= i_cfg_data[0];
                CFG_CAL_TEMP:    r_cal.temp       <= i_cfg_data;
                CFG_CAL_PRESS_A: r_cal.press_a    <= i_cfg_data;
                CFG_CAL_PRESS_B: r_cal.press_b    <= i_cfg_data;
                CFG_CAL_PRESS_C: r_cal.press_c    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    btpc_front u_front (
        .i_push       (push),
        .o_full       (full),
        .i_bus_failed (i_bus_failed),
        .i_press_msb  (i_press_msb),
        .i_press_lsb  (i_press_lsb),
        .i_press_xlsb (i_press_xlsb),
        .i_temp_msb   (i_temp_msb),
        .i_temp_lsb   (i_temp_lsb),
        .i_temp_xlsb  (i_temp_xlsb),
        .i_cal        (r_cal),
        .i_q_full     (w_job_full),
        .o_q_push     (w_job_push),
        .o_job        (w_job_in)
    );

    btpc_fifo #(.W($bits(t_job)), .DEPTH(JOB_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_data  (w_job_in),
        .o_full  (w_job_full),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out),
        .o_empty (w_job_empty)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    btpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cal       (r_cal),
        .i_job_empty (w_job_empty),
        .o_job_pop   (w_job_pop),
        .i_job       (w_job_out),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .o_div       (w_div_req),
        .i_div       (w_div_rsp)
    );

    btpc_fifo #(.W($bits(t_res)), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_temp_centi_deg = w_res_out.temp;
    assign o_pressure_pa    = w_res_out.press;
    assign o_status         = w_res_out.status;

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for the barometric compensation core.
// Depends on btpc_pkg and baro_temp_pressure_compensate_core; prediction is done in-bench.
module tb;
    import btpc_pkg::*;

    localparam logic [2:0] IDX_CALIBRATED = 3'd0;
    localparam logic [2:0] IDX_CAL_TEMP   = 3'd1;
    localparam logic [2:0] IDX_CAL_PA     = 3'd2;
    localparam logic [2:0] IDX_CAL_PB     = 3'd3;
    localparam logic [2:0] IDX_CAL_PC     = 3'd4;
    localparam logic [2:0] IDX_UNUSED     = 3'd7;
    localparam logic [63:0] INT64_MIN     = 64'h8000_0000_0000_0000;

    // raw sensor reading as presented on the input ports
    typedef struct packed {
        logic       bus_failed;
        logic [7:0] pm, pl, px, tm, tl, tx;
    } t_raw;

    // directed stimulus row; typed expectation only where obvious
    typedef struct packed {
        t_raw raw;
        logic has_exp;
        t_res exp_res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_bus_failed = 1'b0;
    logic [7:0]           i_press_msb = '0, i_press_lsb = '0, i_press_xlsb = '0;
    logic [7:0]           i_temp_msb = '0, i_temp_lsb = '0, i_temp_xlsb = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [31:0]   o_temp_centi_deg;
    logic [31:0]          o_pressure_pa;
    logic [2:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CAL_W-1:0]     i_cfg_data = '0;

    // mirror of the calibration registers
    logic        cal_on;
    logic [47:0] cal_words [1:4];

    t_res pending_readings [$];
    bit   failed = 1'b0;
    bit   burst = 1'b0;
    bit   hold_request = 1'b0;

    baro_temp_pressure_compensate_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] sext16(input logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // compensation of one reading against the mirrored calibration
    function automatic t_res compensate(input t_raw r);
        t_res        res;
        logic [31:0] adc_p, adc_t, a, b, m, tfine;
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, num;
        longint      sn, sd;
        res = '{temp: '0, press: '0, status: ST_OK};
        if (!cal_on) begin
            res.status = ST_NOT_INIT;
            return res;
        end
        if (r.bus_failed) begin
            res.status = ST_BUS_ERR;
            return res;
        end
        adc_p = {12'd0, r.pm, r.pl, r.px[7:4]};
        adc_t = {12'd0, r.tm, r.tl, r.tx[7:4]};
        if (adc_p == 32'h80000 || adc_t == 32'h80000) begin
            res.status = ST_DATA_ERR;
            return res;
        end
        t1 = {48'd0, cal_words[1][15:0]}; t2 = sext16(cal_words[1][31:16]);
        t3 = sext16(cal_words[1][47:32]);
        p1 = {48'd0, cal_words[2][15:0]}; p2 = sext16(cal_words[2][31:16]);
        p3 = sext16(cal_words[2][47:32]);
        p4 = sext16(cal_words[3][15:0]);  p5 = sext16(cal_words[3][31:16]);
        p6 = sext16(cal_words[3][47:32]);
        p7 = sext16(cal_words[4][15:0]);  p8 = sext16(cal_words[4][31:16]);
        p9 = sext16(cal_words[4][47:32]);

        // temperature, 32-bit wrap
        a = (adc_t >> 3) - (t1[31:0] << 1);
        m = a * t2[31:0];
        tfine = asr32(m, 11);
        b = (adc_t >> 4) - t1[31:0];
        m = b * b;
        m = asr32(m, 12) * t3[31:0];
        tfine = tfine + asr32(m, 14);
        m = tfine * 32'd5 + 32'd128;
        res.temp = asr32(m, 8);

        // pressure, 64-bit wrap
        v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0) begin
            res.status = ST_COMP_ERR;
            return res;
        end
        p = 64'd1048576 - {32'd0, adc_p};
        num = ((p << 31) - v2) * 64'd3125;
        if (num == INT64_MIN && v1 == '1) begin
            p = INT64_MIN;
        end else begin
            sn = num;
            sd = v1;
            p = sn / sd;
        end
        v1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);
        if (p[63] || p == 64'd0 || p > (64'hFFFF_FFFF << 8)) begin
            res.status = ST_COMP_ERR;
            return res;
        end
        res.press = p[39:8];
        return res;
    endfunction

    // one register write transaction, mirrored into the predictor
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == IDX_CALIBRATED) cal_on = data[0];
        else if (idx <= IDX_CAL_PC) cal_words[idx] = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic cal, input logic [47:0] ct, input logic [47:0] ca,
                            input logic [47:0] cb, input logic [47:0] cc);
        write_reg(IDX_CAL_TEMP, ct);
        write_reg(IDX_CAL_PA, ca);
        write_reg(IDX_CAL_PB, cb);
        write_reg(IDX_CAL_PC, cc);
        write_reg(IDX_CALIBRATED, {47'd0, cal});
    endtask

    // offer one reading and queue its expected result on acceptance
    task automatic send_reading(input t_raw r, input logic has_exp, input t_res exp_res);
        int   gap;
        t_res res;
        gap = burst ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        {i_bus_failed, i_press_msb, i_press_lsb, i_press_xlsb,
         i_temp_msb, i_temp_lsb, i_temp_xlsb} <= r;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        res = compensate(r);
        if (has_exp && res != exp_res) begin
            $display("%0t: table row disagrees with prediction: exp %p got %p",
                     $time, exp_res, res);
            failed = 1'b1;
        end
        pending_readings.push_back(has_exp ? exp_res : res);
    endtask

    function automatic t_raw random_reading();
        t_raw r;
        int   pick;
        r = t_raw'({$urandom, $urandom});
        r.bus_failed = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.bus_failed = 1'b1;
        end else if (pick < 12) begin
            {r.pm, r.pl, r.px[7:4]} = 20'h80000;
        end else if (pick < 16) begin
            {r.tm, r.tl, r.tx[7:4]} = 20'h80000;
        end else if (pick < 70) begin
            // plausible raw range around room conditions
            {r.pm, r.pl, r.px[7:4]} = 20'($urandom_range(250000, 600000));
            {r.tm, r.tl, r.tx[7:4]} = 20'($urandom_range(380000, 560000));
        end
        return r;
    endfunction

    task automatic random_readings(input int count);
        repeat (count) send_reading(random_reading(), 1'b0, '0);
    endtask

    // let everything drain before touching configuration
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int   stall;
        t_res want;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                stall = 400;
                hold_request = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 10);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result: temp %0d press %0d status %0d",
                         $time, o_temp_centi_deg, o_pressure_pa, o_status);
                failed = 1'b1;
            end else begin
                want = pending_readings.pop_front();
                if (o_temp_centi_deg !== want.temp) begin
                    $display("%0t: temp mismatch: exp %0d got %0d",
                             $time, $signed(want.temp), o_temp_centi_deg);
                    failed = 1'b1;
                end
                if (o_pressure_pa !== want.press) begin
                    $display("%0t: pressure mismatch: exp %0d got %0d",
                             $time, want.press, o_pressure_pa);
                    failed = 1'b1;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: exp %0d got %0d",
                             $time, want.status, o_status);
                    failed = 1'b1;
                end
            end
        end
    end

    localparam logic [47:0] NOM_T  = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] NOM_PA = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] NOM_PB = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] NOM_PC = {16'd6000, 16'hC6F8, 16'd15500};

    t_row directed [$];

    initial begin
        t_res zero_res;
        cal_on = 1'b0;
        for (int k = 1; k <= 4; k++) cal_words[k] = '0;
        zero_res = '{temp: '0, press: '0, status: ST_OK};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // uncalibrated after reset
        directed.push_back('{raw: {1'b0, 48'h7E_5A_C0_65_5A_C0}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_NOT_INIT}});
        directed.push_back('{raw: {1'b1, 48'hFF_FF_FF_FF_FF_FF}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_NOT_INIT}});
        foreach (directed[k]) send_reading(directed[k].raw, directed[k].has_exp,
                                           directed[k].exp_res);
        random_readings(15);
        drain();

        // nominal calibration: directed table
        write_reg(IDX_UNUSED, 48'hFFFF_FFFF_FFFF);
        load_cal(1'b1, NOM_T, NOM_PA, NOM_PB, NOM_PC);
        directed.delete();
        directed.push_back('{raw: {1'b1, 48'h65_5A_C0_7E_ED_00}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_BUS_ERR}});
        directed.push_back('{raw: {1'b0, 48'h80_00_00_7E_ED_00}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_DATA_ERR}});
        directed.push_back('{raw: {1'b0, 48'h65_5A_C0_80_00_0F}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_DATA_ERR}});
        directed.push_back('{raw: {1'b0, 48'h80_00_0F_80_00_0F}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_DATA_ERR}});
        directed.push_back('{raw: {1'b1, 48'h80_00_00_80_00_00}, has_exp: 1'b1,
                            exp_res: '{temp: '0, press: '0, status: ST_BUS_ERR}});
        directed.push_back('{raw: {1'b0, 48'h65_5A_C0_7E_ED_00}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'h00_00_00_00_00_00}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'hFF_FF_FF_FF_FF_FF}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'h00_00_0F_FF_FF_F0}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'hFF_FF_F0_00_00_0F}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'h7F_FF_F0_80_00_10}, has_exp: 1'b0,
                            exp_res: zero_res});
        directed.push_back('{raw: {1'b0, 48'h80_00_10_7F_FF_F0}, has_exp: 1'b0,
                            exp_res: zero_res});
        foreach (directed[k]) send_reading(directed[k].raw, directed[k].has_exp,
                                           directed[k].exp_res);
        // long result-side hold while items keep coming
        hold_request = 1'b1;
        burst = 1'b1;
        random_readings(40);
        burst = 1'b0;
        random_readings(160);
        drain();

        // calibration all zero: zero divisor on every computed item
        load_cal(1'b1, '0, '0, '0, '0);
        random_readings(30);
        drain();

        // calibration all ones
        load_cal(1'b1, '1, '1, '1, '1);
        random_readings(40);
        drain();

        // calibration words at random
        for (int ph = 0; ph < 4; ph++) begin
            load_cal(1'b1, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            burst = (ph == 1);
            random_readings(30);
            drain();
        end
        burst = 1'b0;

        // calibrated flag cleared, then nominal again
        write_reg(IDX_CALIBRATED, 48'hFFFF_FFFF_FFFE);
        random_readings(20);
        drain();
        load_cal(1'b1, NOM_T, NOM_PA, NOM_PB, NOM_PC);
        random_readings(80);
        drain();

        if (!failed) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/btpc_pkg.sv
design/btpc_fifo.sv
design/btpc_front.sv
design/btpc_div.sv
design/btpc_back.sv
design/baro_temp_pressure_compensate_core.sv
sim/tb.sv
